// File: rtl/pidf_pkg.sv
// ----------------------------------------------------------------------------
// pidf_pkg
// Shared types for the filtered-derivative PID controller: arithmetic
// operation codes and the command/status groups between controller and
// datapath.
// ----------------------------------------------------------------------------
package pidf_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_GAIN_P     = 3'd0;
    localparam logic [2:0] REG_GAIN_I     = 3'd1;
    localparam logic [2:0] REG_GAIN_D     = 3'd2;
    localparam logic [2:0] REG_FILTER_TAU = 3'd3;
    localparam logic [2:0] REG_OUT_MIN    = 3'd4;
    localparam logic [2:0] REG_OUT_MAX    = 3'd5;

    // Serial operations, issued in this order for every run beat
    typedef enum logic [2:0] {
        OP_P      = 3'd0,   // gain_p * err
        OP_RAW    = 3'd1,   // delta / dt
        OP_ALPHA  = 3'd2,   // dt / (tau + dt)
        OP_DFILT  = 3'd3,   // alpha * (raw - last_derivative)
        OP_IGAIN  = 3'd4,   // gain_i * err
        OP_ISTEP  = 3'd5,   // (gain_i * err) * dt
        OP_DGAIN  = 3'd6    // gain_d * d
    } op_t;

    typedef struct packed {
        logic load;     // capture the input beat
        logic clear;    // clear controller memory, result zero
        logic zero;     // result zero, state kept
        logic prep;     // error, delta, tau + dt
        logic start;    // launch the serial unit
        op_t  op;
        logic sum;      // add the four terms
        logic clamp;    // limit, anti-windup, commit state
        logic emit;     // move result to the output register
    } dp_cmd_t;

    typedef struct packed {
        logic unit_done;
        logic dt_pos;
        logic is_clear;
    } dp_status_t;

endpackage

// File: rtl/pid_filtered_derivative_antiwindup_core.sv
// ----------------------------------------------------------------------------
// pid_filtered_derivative_antiwindup_core
// PID controller in signed fixed point with derivative on measurement,
// first-order derivative filter and clamping anti-windup.
// ----------------------------------------------------------------------------
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   cmd, setpoint, measurement,
//                                             step_time
//   out      output     out_valid / out_ready drive
//   cfg      input      cfg_wen               cfg_index, cfg_data
//
// A run beat is paced by the one shared serial multiplier/divider, which does
// five multiplies and two divides in turn; a clear beat or one with
// step_time <= 0 skips the serial unit.
// One beat is in flight at a time; in_ready is high while idle, also while
// a finished result waits in the output register.
// Reset restores the register defaults and clears the controller memory.
// ----------------------------------------------------------------------------
module pid_filtered_derivative_antiwindup_core #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wen,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic signed [31:0] setpoint,
    input  logic signed [31:0] measurement,
    input  logic signed [31:0] step_time,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] drive
);
    pidf_pkg::dp_cmd_t    ctl;
    pidf_pkg::dp_status_t stat;

    pidf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    pidf_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .setpoint    (setpoint),
        .measurement (measurement),
        .step_time   (step_time),
        .ctl         (ctl),
        .stat        (stat),
        .drive       (drive)
    );

endmodule

// File: rtl/pidf_seq_unit.sv
// ----------------------------------------------------------------------------
// pidf_seq_unit
// Shared shift-add multiplier and restoring divider. Multiply returns
// (a*b) >> FRAC_BITS, divide returns (a << FRAC_BITS) / b for b > 0, both
// truncated toward zero and saturated to VALUE_WIDTH bits.
// ----------------------------------------------------------------------------
module pidf_seq_unit #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          is_div,
    input  logic signed [VALUE_WIDTH-1:0] op_a,
    input  logic signed [VALUE_WIDTH-1:0] op_b,
    output logic                          done,
    output logic signed [VALUE_WIDTH-1:0] result
);
    localparam int W  = VALUE_WIDTH;
    localparam int NW = VALUE_WIDTH + FRAC_BITS;
    localparam int MW = 2 * VALUE_WIDTH + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);
    localparam logic [MW-1:0] POS_LIM = (MW'(1) << (W - 1)) - MW'(1);
    localparam logic [MW-1:0] NEG_LIM = MW'(1) << (W - 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic            div_reg, div_next;
    logic            neg_reg, neg_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [W-1:0]    mcand_reg, mcand_next;
    logic [2*W-1:0]  acc_reg, acc_next;
    logic [W-1:0]    rem_reg, rem_next;
    logic [NW-1:0]   num_reg, num_next;

    logic [W:0]      hi_sum;
    logic [W:0]      shifted;
    logic            fits;
    logic [CW-1:0]   last_cnt;
    logic [MW-1:0]   mag_res;

    function automatic logic [W-1:0] mag_of(input logic signed [W-1:0] x);
        return x[W-1] ? W'(-x) : W'(x);
    endfunction

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        div_next   = div_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        mcand_next = mcand_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        num_next   = num_reg;
        last_cnt   = div_reg ? CW'(NW - 1) : CW'(W - 1);

        hi_sum  = {1'b0, acc_reg[2*W-1:W]} + (acc_reg[0] ? {1'b0, mcand_reg} : '0);
        shifted = {rem_reg, num_reg[NW-1]};
        fits    = shifted >= {1'b0, mcand_reg};

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            div_next  = is_div;
            rem_next  = '0;
            if (is_div)
            begin
                neg_next   = op_a[W-1];
                mcand_next = W'(op_b);
                num_next   = {mag_of(op_a), {FRAC_BITS{1'b0}}};
            end
            else
            begin
                neg_next   = op_a[W-1] ^ op_b[W-1];
                mcand_next = mag_of(op_a);
                acc_next   = {{W{1'b0}}, mag_of(op_b)};
            end
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                rem_next = fits ? W'(shifted - {1'b0, mcand_reg}) : W'(shifted);
                num_next = {num_reg[NW-2:0], fits};
            end
            else
            begin
                acc_next = {hi_sum, acc_reg[W-1:1]};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == last_cnt)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        mag_res = div_reg ? MW'(num_reg) : MW'(acc_reg >> FRAC_BITS);
        if (neg_reg)
            result = (mag_res > NEG_LIM) ? {1'b1, {(W-1){1'b0}}} : W'(-mag_res);
        else
            result = (mag_res > POS_LIM) ? {1'b0, {(W-1){1'b1}}} : W'(mag_res);
    end

    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg   <= div_next;
        neg_reg   <= neg_next;
        mcand_reg <= mcand_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        num_reg   <= num_next;
    end

endmodule

// File: rtl/pidf_datapath.sv
// ----------------------------------------------------------------------------
// pidf_datapath
// Configuration registers, controller memory, operand selection for the
// shared serial unit, four-term sum, output clamp and anti-windup.
// ----------------------------------------------------------------------------
module pidf_datapath #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wen,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 cmd,
    input  logic signed [31:0]   setpoint,
    input  logic signed [31:0]   measurement,
    input  logic signed [31:0]   step_time,
    input  pidf_pkg::dp_cmd_t    ctl,
    output pidf_pkg::dp_status_t stat,
    output logic signed [31:0]   drive
);
    localparam int W = VALUE_WIDTH;
    localparam logic signed [63:0] VMAX = (64'sd1 <<< (W - 1)) - 64'sd1;
    localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;
    localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;

    function automatic logic signed [W-1:0] sat_w(input logic signed [63:0] x);
        if (x > VMAX)
            return W'(VMAX);
        if (x < VMIN)
            return W'(VMIN);
        return W'(x);
    endfunction

    // configuration
    logic signed [31:0] gp_reg, gi_reg, gd_reg, omin_reg, omax_reg;
    logic [30:0]        tau_reg;

    // beat capture
    logic                  clr_reg;
    logic signed [W-1:0]   sp_reg, meas_reg, dt_reg;

    // memory
    logic signed [W-1:0]   isum_reg, isum_next;
    logic signed [W-1:0]   lm_reg, ld_reg;
    logic                  first_reg;

    // intermediates
    logic signed [W-1:0]   err_reg, delta_reg, tdt_reg;
    logic signed [W-1:0]   p_reg, raw_reg, alpha_reg, d_reg, t_reg, istep_reg, gdd_reg;
    logic signed [W+1:0]   sum_reg;
    logic signed [W-1:0]   res_reg, res_next;
    logic signed [31:0]    drive_reg;

    logic signed [W-1:0]   lm_eff, lo_lim, hi_lim;
    logic signed [W-1:0]   op_a, op_b;
    logic                  is_div;
    logic                  unit_done;
    logic signed [W-1:0]   unit_res;

    assign lm_eff = first_reg ? meas_reg : lm_reg;
    assign lo_lim = sat_w(64'(omin_reg));
    assign hi_lim = sat_w(64'(omax_reg));

    always_comb
    begin
        op_a   = '0;
        op_b   = err_reg;
        is_div = 1'b0;
        case (ctl.op)
            pidf_pkg::OP_P:
            begin
                op_a = sat_w(64'(gp_reg));
                op_b = err_reg;
            end
            pidf_pkg::OP_RAW:
            begin
                op_a   = delta_reg;
                op_b   = dt_reg;
                is_div = 1'b1;
            end
            pidf_pkg::OP_ALPHA:
            begin
                op_a   = dt_reg;
                op_b   = tdt_reg;
                is_div = 1'b1;
            end
            pidf_pkg::OP_DFILT:
            begin
                op_a = alpha_reg;
                op_b = sat_w(64'(raw_reg) - 64'(ld_reg));
            end
            pidf_pkg::OP_IGAIN:
            begin
                op_a = sat_w(64'(gi_reg));
                op_b = err_reg;
            end
            pidf_pkg::OP_ISTEP:
            begin
                op_a = t_reg;
                op_b = dt_reg;
            end
            pidf_pkg::OP_DGAIN:
            begin
                op_a = sat_w(64'(gd_reg));
                op_b = d_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    pidf_seq_unit #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ctl.start),
        .is_div (is_div),
        .op_a   (op_a),
        .op_b   (op_b),
        .done   (unit_done),
        .result (unit_res)
    );

    // clamp and anti-windup
    always_comb
    begin
        isum_next = isum_reg;
        res_next  = res_reg;
        if (64'(sum_reg) > 64'(hi_lim))
        begin
            res_next = hi_lim;
            if (err_reg < 0)
                isum_next = sat_w(64'(isum_reg) + 64'(istep_reg));
        end
        else if (64'(sum_reg) < 64'(lo_lim))
        begin
            res_next = lo_lim;
            if (err_reg > 0)
                isum_next = sat_w(64'(isum_reg) + 64'(istep_reg));
        end
        else
        begin
            res_next  = W'(sum_reg);
            isum_next = sat_w(64'(isum_reg) + 64'(istep_reg));
        end
    end

    assign stat.unit_done = unit_done;
    assign stat.dt_pos    = dt_reg > 0;
    assign stat.is_clear  = clr_reg;
    assign drive          = drive_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gp_reg    <= '0;
            gi_reg    <= '0;
            gd_reg    <= '0;
            tau_reg   <= '0;
            omin_reg  <= -ONE;
            omax_reg  <= ONE;
            isum_reg  <= '0;
            lm_reg    <= '0;
            ld_reg    <= '0;
            first_reg <= 1'b1;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    pidf_pkg::REG_GAIN_P:     gp_reg   <= cfg_data;
                    pidf_pkg::REG_GAIN_I:     gi_reg   <= cfg_data;
                    pidf_pkg::REG_GAIN_D:     gd_reg   <= cfg_data;
                    pidf_pkg::REG_FILTER_TAU: tau_reg  <= cfg_data[30:0];
                    pidf_pkg::REG_OUT_MIN:    omin_reg <= cfg_data;
                    pidf_pkg::REG_OUT_MAX:    omax_reg <= cfg_data;
                    default:                  ;
                endcase
            end
            if (ctl.clear)
            begin
                isum_reg  <= '0;
                lm_reg    <= '0;
                ld_reg    <= '0;
                first_reg <= 1'b1;
            end
            else if (ctl.prep)
            begin
                first_reg <= 1'b0;
            end
            else if (ctl.clamp)
            begin
                isum_reg <= isum_next;
                lm_reg   <= meas_reg;
                ld_reg   <= d_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            clr_reg  <= cmd;
            sp_reg   <= sat_w(64'(setpoint));
            meas_reg <= sat_w(64'(measurement));
            dt_reg   <= sat_w(64'(step_time));
        end
        if (ctl.prep)
        begin
            err_reg   <= sat_w(64'(sp_reg) - 64'(meas_reg));
            delta_reg <= sat_w(64'(meas_reg) - 64'(lm_eff));
            tdt_reg   <= sat_w(64'(sat_w(64'(tau_reg))) + 64'(dt_reg));
        end
        if (unit_done)
        begin
            case (ctl.op)
                pidf_pkg::OP_P:     p_reg     <= unit_res;
                pidf_pkg::OP_RAW:   raw_reg   <= sat_w(-64'(unit_res));
                pidf_pkg::OP_ALPHA: alpha_reg <= unit_res;
                pidf_pkg::OP_DFILT: d_reg     <= sat_w(64'(ld_reg) + 64'(unit_res));
                pidf_pkg::OP_IGAIN: t_reg     <= unit_res;
                pidf_pkg::OP_ISTEP: istep_reg <= unit_res;
                pidf_pkg::OP_DGAIN: gdd_reg   <= unit_res;
                default:            ;
            endcase
        end
        if (ctl.sum)
            sum_reg <= (W+2)'(64'(p_reg) + 64'(isum_reg) + 64'(istep_reg) + 64'(gdd_reg));
        if (ctl.clear || ctl.zero)
            res_reg <= '0;
        else if (ctl.clamp)
            res_reg <= res_next;
        if (ctl.emit)
            drive_reg <= 32'(64'(res_reg));
    end

endmodule

// File: rtl/pidf_ctrl.sv
// ----------------------------------------------------------------------------
// pidf_ctrl
// Sequencer: accepts a beat, walks the serial operations in order, then
// sums, clamps and hands the result to the output register.
// ----------------------------------------------------------------------------
module pidf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  pidf_pkg::dp_status_t stat,
    output pidf_pkg::dp_cmd_t    ctl
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PREP  = 7'b0000010,
        S_START = 7'b0000100,
        S_WAIT  = 7'b0001000,
        S_SUM   = 7'b0010000,
        S_CLAMP = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    pidf_pkg::op_t   op_reg, op_next;
    logic            ovalid_reg, ovalid_next;

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = ovalid_reg;

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        ovalid_next = ovalid_reg;
        ctl         = '0;
        ctl.op      = op_reg;
        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (stat.is_clear)
                begin
                    ctl.clear  = 1'b1;
                    state_next = S_DONE;
                end
                else if (!stat.dt_pos)
                begin
                    ctl.zero   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ctl.prep   = 1'b1;
                    op_next    = pidf_pkg::OP_P;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                ctl.start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (stat.unit_done)
                begin
                    if (op_reg == pidf_pkg::OP_DGAIN)
                        state_next = S_SUM;
                    else
                    begin
                        op_next    = pidf_pkg::op_t'(3'(op_reg) + 3'd1);
                        state_next = S_START;
                    end
                end
            end
            S_SUM:
            begin
                ctl.sum    = 1'b1;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                ctl.clamp  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!ovalid_reg || out_ready)
                begin
                    ctl.emit    = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= pidf_pkg::OP_P;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

// File: rtl/pidf_checker.sv
// ----------------------------------------------------------------------------
// pidf_checker
// Port-level checks on the controller core, bound to the top level.
// ----------------------------------------------------------------------------
module pidf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] drive
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive))
        else $error("result dropped or changed while stalled");

    // one beat in flight: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a beat is in flight");

    // a new result appears only at the end of a beat
    a_new_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a beat in flight");

endmodule

bind pid_filtered_derivative_antiwindup_core pidf_checker u_pidf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive)
);

// File: bench/tb_pid_filtered_derivative_antiwindup_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller bench
// Drives control steps, clears and non-positive time steps through the
// valid/ready input, computes each expected drive value in a signed Q16.16
// fixed-point model kept beside the block, and compares every output beat
// in order.
// ----------------------------------------------------------------------------
module tb_pid_filtered_derivative_antiwindup_core;

    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;
    localparam int     FRAC = 16;
    localparam int     CYCLE_LIMIT = 3000000;
    localparam logic   CMD_RUN = 1'b0;
    localparam logic   CMD_CLEAR = 1'b1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wen = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        cmd = 1'b0;
    logic signed [31:0] setpoint = '0;
    logic signed [31:0] measurement = '0;
    logic signed [31:0] step_time = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic signed [31:0] drive;

    pid_filtered_derivative_antiwindup_core u_top (
        .clk(clk), .rst_n(rst_n), .cfg_wen(cfg_wen), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .setpoint(setpoint), .measurement(measurement),
        .step_time(step_time), .out_valid(out_valid), .out_ready(out_ready),
        .drive(drive)
    );

    always #6 clk = ~clk;

    // controller model state
    longint kp, ki, kd, tau, lim_lo, lim_hi;
    longint integ, prev_meas, prev_deriv;
    bit     fresh;

    logic [31:0] drive_q[$];
    int   errors = 0;
    int   cycles = 0;
    bit   idle_on = 1'b1;
    int   hold_off = 0;

    function automatic longint clip(longint x);
        if (x > VMAX) return VMAX;
        if (x < VMIN) return VMIN;
        return x;
    endfunction

    // magnitudes here never exceed 2^31, so 128-bit products are exact
    function automatic longint fx_mult(longint a, longint b);
        logic [127:0] m;
        bit neg;
        neg = (a < 0) != (b < 0);
        m = 128'((a < 0) ? -a : a) * 128'((b < 0) ? -b : b);
        m = m >> FRAC;
        if (neg) return (m > 128'(VMAX) + 1) ? VMIN : -longint'(m);
        return (m > 128'(VMAX)) ? VMAX : longint'(m);
    endfunction

    function automatic longint fx_divide(longint n, longint d);
        logic [127:0] q;
        q = (128'((n < 0) ? -n : n) << FRAC) / 128'(d);
        if (n < 0) return (q > 128'(VMAX) + 1) ? VMIN : -longint'(q);
        return (q > 128'(VMAX)) ? VMAX : longint'(q);
    endfunction

    function automatic void model_clear();
        integ = 0;
        prev_meas = 0;
        prev_deriv = 0;
        fresh = 1'b1;
    endfunction

    function automatic logic [31:0] predict_drive(logic c, longint sp, longint ms,
                                                  longint dt);
        longint err, p, raw, alpha, d, istep, total, outv;
        if (c == CMD_CLEAR) begin
            model_clear();
            return '0;
        end
        if (dt <= 0) return '0;
        if (fresh) begin
            prev_meas = ms;
            fresh = 1'b0;
        end
        err = clip(sp - ms);
        p = fx_mult(kp, err);
        raw = clip(-fx_divide(clip(ms - prev_meas), dt));
        alpha = fx_divide(dt, clip(tau + dt));
        d = clip(prev_deriv + fx_mult(alpha, clip(raw - prev_deriv)));
        istep = fx_mult(fx_mult(ki, err), dt);
        total = p + integ + istep + fx_mult(kd, d);
        if (total > lim_hi) begin
            outv = lim_hi;
            if (err < 0) integ = clip(integ + istep);
        end else if (total < lim_lo) begin
            outv = lim_lo;
            if (err > 0) integ = clip(integ + istep);
        end else begin
            outv = total;
            integ = clip(integ + istep);
        end
        prev_meas = ms;
        prev_deriv = d;
        return outv[31:0];
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wen <= 1'b0;
        case (idx)
            pidf_pkg::REG_GAIN_P:     kp = longint'(signed'(val));
            pidf_pkg::REG_GAIN_I:     ki = longint'(signed'(val));
            pidf_pkg::REG_GAIN_D:     kd = longint'(signed'(val));
            pidf_pkg::REG_FILTER_TAU: tau = longint'(val[30:0]);
            pidf_pkg::REG_OUT_MIN:    lim_lo = longint'(signed'(val));
            pidf_pkg::REG_OUT_MAX:    lim_hi = longint'(signed'(val));
            default: ;
        endcase
        @(posedge clk);
    endtask

    // valid stays high after the accept; an idle gap or drain() drops it
    task automatic send_beat(logic c, logic [31:0] sp, logic [31:0] ms,
                             logic [31:0] dt);
        while (idle_on && $urandom_range(99) < 7) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        setpoint <= sp;
        measurement <= ms;
        step_time <= dt;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        drive_q.push_back(predict_drive(c, longint'(signed'(sp)),
                                        longint'(signed'(ms)), longint'(signed'(dt))));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (drive_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // run item with mostly modest values so the loop stays unsaturated
    task automatic send_random_run();
        logic [31:0] sp, ms, dt;
        sp = $urandom_range(9) == 0 ? $urandom : 32'($signed($urandom_range(262144)) - 131072);
        ms = $urandom_range(9) == 0 ? $urandom : 32'($signed($urandom_range(262144)) - 131072);
        case ($urandom_range(19))
            0: dt = $urandom;
            1: dt = -$urandom_range(65536);
            2: dt = 32'h7FFFFFFF;
            default: dt = $urandom_range(1, 16384);
        endcase
        send_beat(CMD_RUN, sp, ms, dt);
    endtask

    task automatic test_defaults();
        send_beat(CMD_RUN, 32'h0001_0000, 32'h0, 32'h0000_0400);
        send_beat(CMD_RUN, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        send_beat(CMD_RUN, 32'h80000000, 32'h7FFFFFFF, 32'h1);
        drain();
    endtask

    task automatic test_directed();
        write_reg(pidf_pkg::REG_GAIN_P, 32'h0002_0000);
        write_reg(pidf_pkg::REG_GAIN_I, 32'h0001_8000);
        write_reg(pidf_pkg::REG_GAIN_D, 32'h0000_4000);
        write_reg(pidf_pkg::REG_FILTER_TAU, 32'h0000_0800);
        write_reg(pidf_pkg::REG_OUT_MIN, 32'hFFFC_0000);
        write_reg(pidf_pkg::REG_OUT_MAX, 32'h0004_0000);
        // two steps with the new settings
        send_beat(CMD_RUN, 32'h0001_0000, 32'h0000_8000, 32'h0000_0100);
        send_beat(CMD_RUN, 32'h0001_0000, 32'h0000_9000, 32'h0000_0100);
        // non-positive step times: zero result, state untouched
        send_beat(CMD_RUN, 32'h0001_0000, 32'h0000_A000, 32'h0);
        send_beat(CMD_RUN, 32'h0001_0000, 32'h0000_A000, 32'h80000000);
        send_beat(CMD_RUN, 32'h0001_0000, 32'h0000_A000, 32'hFFFFFFFF);
        // drive into both limits, windup hold
        send_beat(CMD_RUN, 32'h7FFFFFFF, 32'h0, 32'h0001_0000);
        send_beat(CMD_RUN, 32'h7FFFFFFF, 32'h0, 32'h0001_0000);
        send_beat(CMD_RUN, 32'h80000000, 32'h7FFFFFFF, 32'h0001_0000);
        send_beat(CMD_RUN, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
        // clear, then first step again with huge payload bits
        send_beat(CMD_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_beat(CMD_RUN, 32'h0, 32'h7FFFFFFF, 32'h0000_0001);
        send_beat(CMD_RUN, 32'h0, 32'h80000000, 32'h0000_0001);
        drain();
        // crossed limits: upper test wins
        write_reg(pidf_pkg::REG_OUT_MIN, 32'h0001_0000);
        write_reg(pidf_pkg::REG_OUT_MAX, 32'hFFFF_0000);
        send_beat(CMD_RUN, 32'h0000_1000, 32'h0, 32'h0000_0100);
        send_beat(CMD_RUN, 32'hFFF0_0000, 32'h0, 32'h0000_0100);
        drain();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_reg(pidf_pkg::REG_GAIN_P, 32'h7FFFFFFF);
                    write_reg(pidf_pkg::REG_GAIN_I, 32'h80000000);
                    write_reg(pidf_pkg::REG_GAIN_D, 32'h7FFFFFFF);
                    write_reg(pidf_pkg::REG_FILTER_TAU, 32'hFFFFFFFF);
                    write_reg(pidf_pkg::REG_OUT_MIN, 32'h80000000);
                    write_reg(pidf_pkg::REG_OUT_MAX, 32'h7FFFFFFF);
                end
                1: begin
                    write_reg(pidf_pkg::REG_GAIN_P, 32'h80000000);
                    write_reg(pidf_pkg::REG_GAIN_I, 32'h7FFFFFFF);
                    write_reg(pidf_pkg::REG_GAIN_D, 32'h80000000);
                    write_reg(pidf_pkg::REG_FILTER_TAU, 32'h0);
                end
                default: begin
                    write_reg(pidf_pkg::REG_GAIN_P,
                              32'($signed($urandom_range(524288)) - 262144));
                    write_reg(pidf_pkg::REG_GAIN_I,
                              32'($signed($urandom_range(524288)) - 262144));
                    write_reg(pidf_pkg::REG_GAIN_D, $urandom_range(3) == 0 ? $urandom
                              : 32'($signed($urandom_range(131072)) - 65536));
                    write_reg(pidf_pkg::REG_FILTER_TAU, $urandom_range(3) == 0 ? $urandom
                              : $urandom_range(65536));
                    write_reg(pidf_pkg::REG_OUT_MIN, 32'(-$signed($urandom_range(1 << 20))));
                    write_reg(pidf_pkg::REG_OUT_MAX, $urandom_range(1 << 20));
                end
            endcase
            for (int k = 0; k < 225; k++) begin
                if ($urandom_range(39) == 0) send_beat(CMD_CLEAR, $urandom, $urandom, $urandom);
                else send_random_run();
            end
            drain();
        end
    endtask

    task automatic test_stall_and_pause();
        idle_on = 1'b0;
        // long receiver hold while items keep coming
        hold_off = 1500;
        for (int k = 0; k < 10; k++) send_random_run();
        drain();
        // sender waits for everything, then bursts without gaps
        for (int k = 0; k < 40; k++) send_random_run();
        drain();
        idle_on = 1'b1;
    endtask

    // receiver: random stalls plus an explicit hold-off window
    always @(posedge clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= !(idle_on && $urandom_range(99) < 7);
        end
    end

    // check each output beat against the oldest expectation
    always @(posedge clk) begin
        logic [31:0] want;
        if (rst_n && out_valid && out_ready) begin
            if (drive_q.size() == 0) begin
                $display("%0t: unexpected drive beat, expected none, actual %h", $time, drive);
                errors++;
            end else begin
                want = drive_q.pop_front();
                if (drive !== want) begin
                    $display("%0t: drive expected %h actual %h", $time, want, drive);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        kp = 0; ki = 0; kd = 0; tau = 0;
        lim_lo = -65536; lim_hi = 65536;
        model_clear();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_directed();
        test_stall_and_pause();
        test_random_settings();
        drain();
        if (errors == 0 && drive_q.size() == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
